FILE: rtl/mtt_pkg.sv
package mtt_pkg;

    localparam int ID_W      = 31;
    localparam int IN_TIME_W = 32;
    localparam int KIND_W    = 3;
    localparam int REQ_W     = 2;

    // Id space wraps at this value
    localparam logic [ID_W-1:0] ID_MAX = 31'h7fff_ffff;

    localparam logic [REQ_W-1:0] REQ_SCHED  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CANCEL = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

    localparam logic [KIND_W-1:0] RK_ASSIGNED  = 3'd0;
    localparam logic [KIND_W-1:0] RK_FULL      = 3'd1;
    localparam logic [KIND_W-1:0] RK_CANCEL    = 3'd2;
    localparam logic [KIND_W-1:0] RK_FIRED     = 3'd3;
    localparam logic [KIND_W-1:0] RK_TICK_DONE = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic              last;
    } result_t;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_SEARCH = 6'b000100,
        S_EMIT   = 6'b001000,
        S_COMMIT = 6'b010000,
        S_FINAL  = 6'b100000
    } seq_state_t;

endpackage

FILE: rtl/mtt_req_if.sv
interface mtt_req_if import mtt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [REQ_W-1:0]     req_type;
    logic [IN_TIME_W-1:0] interval;
    logic                 repeat_req;
    logic [ID_W-1:0]      timer_id;
    logic [IN_TIME_W-1:0] elapsed;

    modport source (
        output valid, req_type, interval, repeat_req, timer_id, elapsed,
        input  ready
    );
    modport sink (
        input  valid, req_type, interval, repeat_req, timer_id, elapsed,
        output ready
    );
endinterface

FILE: rtl/mtt_rsp_if.sv
interface mtt_rsp_if import mtt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] result_kind;
    logic [ID_W-1:0]   result_id;
    logic              last;

    modport source (
        output valid, result_kind, result_id, last,
        input  ready
    );
    modport sink (
        input  valid, result_kind, result_id, last,
        output ready
    );
endinterface

FILE: rtl/mtt_time_alu.sv
module mtt_time_alu #(
    parameter int TIME_BITS = 32
) (
    input  logic                 sub_mode,
    input  logic [TIME_BITS:0]   cnt,
    input  logic [TIME_BITS-1:0] elapsed,
    input  logic [TIME_BITS-1:0] period,
    output logic [TIME_BITS:0]   result,
    output logic                 le_zero
);

    localparam int TB = TIME_BITS;

    logic [TB:0]   room;
    logic [TB+1:0] op_x;
    logic [TB+1:0] op_y;
    logic [TB+1:0] sum;
    logic          under;

    // Offset the countdown so its floor sits at zero, then one adder serves
    // both the saturating subtract and the reload add.
    assign room  = {~cnt[TB], cnt[TB-1:0]};
    assign op_x  = sub_mode ? {1'b0, room} : {cnt[TB], cnt};
    assign op_y  = sub_mode ? ~{2'b00, elapsed} : {2'b00, period};
    assign sum   = op_x + op_y + {{(TB+1){1'b0}}, sub_mode};
    assign under = sub_mode & sum[TB+1];

    always_comb
    begin
        if (under)
        begin
            result = {1'b1, {TB{1'b0}}};
        end
        else if (sub_mode)
        begin
            result = {~sum[TB], sum[TB-1:0]};
        end
        else
        begin
            result = sum[TB:0];
        end
    end

    assign le_zero = result[TB] | (result == '0);

endmodule

FILE: rtl/mtt_id_cmp.sv
module mtt_id_cmp import mtt_pkg::*; (
    input  logic [ID_W-1:0] a,
    input  logic [ID_W-1:0] b,
    output logic            eq,
    output logic            lt
);

    logic [ID_W:0] diff;

    assign diff = {1'b0, a} - {1'b0, b};
    assign lt   = diff[ID_W];
    assign eq   = (diff == '0);

endmodule

FILE: rtl/mtt_table.sv
module mtt_table import mtt_pkg::*; #(
    parameter int NUM_TIMERS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    mtt_req_if.sink     req,
    output logic        push_valid,
    input  logic        push_ready,
    output result_t     push_data
);

    localparam int N     = NUM_TIMERS;
    localparam int TB    = TIME_BITS;
    localparam int IDX_W = (N > 1) ? $clog2(N) : 1;
    localparam int EXT_W = 64;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N - 1);

    // control state
    seq_state_t       state_reg, state_next;
    logic [N-1:0]     valid_reg, valid_next;
    logic [N-1:0]     fired_reg, fired_next;
    logic [ID_W-1:0]  id_counter_reg, id_counter_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             hit_found_reg, hit_found_next;
    logic             free_found_reg, free_found_next;
    logic             best_found_reg, best_found_next;

    // working registers
    logic [REQ_W-1:0] op_reg, op_next;
    logic [ID_W-1:0]  key_reg, key_next;
    logic [TB-1:0]    time_reg, time_next;
    logic             repeat_reg, repeat_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [ID_W-1:0]  best_id_reg, best_id_next;

    // slot store
    logic [ID_W-1:0]  slot_id_reg       [N];
    logic [TB:0]      slot_cnt_reg      [N];
    logic [TB-1:0]    slot_period_reg   [N];
    logic [N-1:0]     slot_periodic_reg;
    logic [N-1:0]     slot_cancel_reg;

    logic [IDX_W-1:0] rd_idx;
    logic [ID_W-1:0]  rd_id;
    logic [TB:0]      rd_cnt;
    logic [TB-1:0]    rd_period;
    logic             rd_periodic;
    logic             rd_cancel;
    logic             rd_valid;

    logic [ID_W-1:0]  cmp_b;
    logic             cmp_eq;
    logic             cmp_lt;
    logic             alu_sub;
    logic [TB:0]      alu_res;
    logic             alu_le_zero;

    logic             accept;
    logic             is_active_req;
    logic             slot_avail;
    logic [IDX_W-1:0] wr_idx;
    logic [EXT_W-1:0] interval_ext;
    logic [EXT_W-1:0] elapsed_ext;

    assign rd_idx      = (state_reg == S_EMIT) ? best_idx_reg : idx_reg;
    assign rd_id       = slot_id_reg[rd_idx];
    assign rd_cnt      = slot_cnt_reg[rd_idx];
    assign rd_period   = slot_period_reg[rd_idx];
    assign rd_periodic = slot_periodic_reg[rd_idx];
    assign rd_cancel   = slot_cancel_reg[rd_idx];
    assign rd_valid    = valid_reg[rd_idx];

    assign cmp_b   = (state_reg == S_SEARCH) ? best_id_reg : key_reg;
    assign alu_sub = (state_reg == S_SCAN);

    mtt_id_cmp u_cmp (
        .a  (rd_id),
        .b  (cmp_b),
        .eq (cmp_eq),
        .lt (cmp_lt)
    );

    mtt_time_alu #(
        .TIME_BITS (TB)
    ) u_alu (
        .sub_mode (alu_sub),
        .cnt      (rd_cnt),
        .elapsed  (time_reg),
        .period   (rd_period),
        .result   (alu_res),
        .le_zero  (alu_le_zero)
    );

    assign req.ready     = (state_reg == S_IDLE);
    assign accept        = req.valid & req.ready;
    assign is_active_req = (req.req_type == REQ_SCHED) || (req.req_type == REQ_CANCEL)
                           || (req.req_type == REQ_TICK);
    assign slot_avail    = hit_found_reg | free_found_reg;
    assign wr_idx        = hit_found_reg ? hit_idx_reg : free_idx_reg;
    assign interval_ext  = {{(EXT_W-IN_TIME_W){1'b0}}, req.interval};
    assign elapsed_ext   = {{(EXT_W-IN_TIME_W){1'b0}}, req.elapsed};

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        fired_next      = fired_reg;
        id_counter_next = id_counter_reg;
        idx_next        = idx_reg;
        hit_found_next  = hit_found_reg;
        free_found_next = free_found_reg;
        best_found_next = best_found_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        time_next       = time_reg;
        repeat_next     = repeat_reg;
        hit_idx_next    = hit_idx_reg;
        free_idx_next   = free_idx_reg;
        best_idx_next   = best_idx_reg;
        best_id_next    = best_id_reg;
        push_valid      = 1'b0;
        push_data       = '{kind: RK_TICK_DONE, id: '0, last: 1'b1};

        case (state_reg)
            S_IDLE:
            begin
                if (accept && is_active_req)
                begin
                    op_next         = req.req_type;
                    key_next        = (req.req_type == REQ_SCHED) ?
                                      ((id_counter_reg + ID_W'(1)) & ID_MAX) : req.timer_id;
                    time_next       = (req.req_type == REQ_SCHED) ?
                                      interval_ext[TB-1:0] : elapsed_ext[TB-1:0];
                    repeat_next     = req.repeat_req;
                    idx_next        = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (op_reg == REQ_TICK)
                begin
                    if (rd_valid)
                    begin
                        if (rd_cancel)
                        begin
                            valid_next[idx_reg] = 1'b0;
                        end
                        else
                        begin
                            fired_next[idx_reg] = alu_le_zero;
                        end
                    end
                end
                else
                begin
                    if (rd_valid && cmp_eq && !hit_found_reg)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = idx_reg;
                    end
                    if (!rd_valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                end
                if (idx_reg == LAST_IDX)
                begin
                    idx_next        = '0;
                    best_found_next = 1'b0;
                    state_next      = (op_reg == REQ_TICK) ? S_SEARCH : S_COMMIT;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_SEARCH:
            begin
                if (!(|fired_reg))
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    if (fired_reg[idx_reg] && (!best_found_reg || cmp_lt))
                    begin
                        best_found_next = 1'b1;
                        best_idx_next   = idx_reg;
                        best_id_next    = rd_id;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_next   = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end

            S_EMIT:
            begin
                push_valid = 1'b1;
                push_data  = '{kind: RK_FIRED, id: best_id_reg, last: 1'b0};
                if (push_ready)
                begin
                    fired_next[best_idx_reg] = 1'b0;
                    if (!rd_periodic)
                    begin
                        valid_next[best_idx_reg] = 1'b0;
                    end
                    best_found_next = 1'b0;
                    idx_next        = '0;
                    state_next      = S_SEARCH;
                end
            end

            S_COMMIT:
            begin
                push_valid = 1'b1;
                if (op_reg == REQ_SCHED)
                begin
                    if (slot_avail)
                    begin
                        push_data = '{kind: RK_ASSIGNED, id: key_reg, last: 1'b1};
                    end
                    else
                    begin
                        push_data = '{kind: RK_FULL, id: '0, last: 1'b1};
                    end
                end
                else
                begin
                    push_data = '{kind: RK_CANCEL, id: '0, last: 1'b1};
                end
                if (push_ready)
                begin
                    if ((op_reg == REQ_SCHED) && slot_avail)
                    begin
                        valid_next[wr_idx] = 1'b1;
                        id_counter_next    = key_reg;
                    end
                    state_next = S_IDLE;
                end
            end

            S_FINAL:
            begin
                push_valid = 1'b1;
                push_data  = '{kind: RK_TICK_DONE, id: '0, last: 1'b1};
                if (push_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            fired_reg      <= '0;
            id_counter_reg <= '0;
            idx_reg        <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            fired_reg      <= fired_next;
            id_counter_reg <= id_counter_next;
            idx_reg        <= idx_next;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            best_found_reg <= best_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        time_reg     <= time_next;
        repeat_reg   <= repeat_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        best_idx_reg <= best_idx_next;
        best_id_reg  <= best_id_next;
    end

    // slot store writes
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_SCAN) && (op_reg == REQ_TICK) && rd_valid && !rd_cancel)
        begin
            slot_cnt_reg[idx_reg] <= alu_res;
        end
        if ((state_reg == S_EMIT) && push_ready && rd_periodic)
        begin
            slot_cnt_reg[best_idx_reg] <= alu_res;
        end
        if ((state_reg == S_COMMIT) && push_ready)
        begin
            if ((op_reg == REQ_SCHED) && slot_avail)
            begin
                slot_id_reg[wr_idx]       <= key_reg;
                slot_cnt_reg[wr_idx]      <= {1'b0, time_reg};
                slot_period_reg[wr_idx]   <= time_reg;
                slot_periodic_reg[wr_idx] <= repeat_reg;
                slot_cancel_reg[wr_idx]   <= 1'b0;
            end
            if ((op_reg == REQ_CANCEL) && hit_found_reg)
            begin
                slot_cancel_reg[hit_idx_reg] <= 1'b1;
            end
        end
    end

endmodule

FILE: rtl/mtt_out_reg.sv
module mtt_out_reg import mtt_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  result_t  push_data,
    mtt_rsp_if.source rsp
);

    logic    full_reg, full_next;
    result_t data_reg;

    // Take a new word when empty, or when the held one leaves in the same cycle
    assign push_ready = !full_reg || rsp.ready;
    assign full_next  = push_ready ? push_valid : full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ready && push_valid)
        begin
            data_reg <= push_data;
        end
    end

    assign rsp.valid       = full_reg;
    assign rsp.result_kind = data_reg.kind;
    assign rsp.result_id   = data_reg.id;
    assign rsp.last        = data_reg.last;

endmodule

FILE: rtl/multi_timer_table.sv
// Channel | Dir | Word contents                                   | Accepted when
// req     | in  | req_type, interval, repeat_req, timer_id, elapsed | valid && ready
// rsp     | out | result_kind, result_id, last                    | valid && ready
//
// Schedule and cancel scan every slot, then commit one result word.
// A tick first updates every countdown, then searches all slots for the
// lowest fired id and emits it, once per fired timer, then makes a last
// search step that finds nothing left and emits the done word. The single
// slot read port and the shared id comparator and time adder make each
// scan visit one slot at a time.
// Reset clears the slot valid bits and the id counter at once; slot contents
// need no clearing. The request side is held off while an item is in work;
// a stalled output holds the sequencer in its emit, commit or final step.
module multi_timer_table import mtt_pkg::*; #(
    parameter int NUM_TIMERS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    mtt_req_if.sink   req,
    mtt_rsp_if.source rsp
);

    logic    push_valid;
    logic    push_ready;
    result_t push_data;

    // Sequencer, slot store and shared arithmetic
    mtt_table #(
        .NUM_TIMERS (NUM_TIMERS),
        .TIME_BITS  (TIME_BITS)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Output register: hold each result word until the sink takes it
    mtt_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .rsp        (rsp)
    );

    // An accepted request blocks the next one while it is in work
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.req_type == REQ_SCHED ||
         req.req_type == REQ_CANCEL || req.req_type == REQ_TICK)) |=> !req.ready)
        else $error("request side ready right after accepting a request");

    // Only fired words are not final
    a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> ((rsp.result_kind == RK_FIRED) != rsp.last))
        else $error("last flag disagrees with result kind");

    // Kinds without an id carry zero
    a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.result_kind == RK_FULL || rsp.result_kind == RK_CANCEL ||
         rsp.result_kind == RK_TICK_DONE)) |-> (rsp.result_id == '0))
        else $error("nonzero id on a result kind without an id");

    // When idle, any pending word must close its item
    a_idle_holds_last: assert property (@(posedge clk) disable iff (!rst_n)
        (req.ready && rsp.valid) |-> rsp.last)
        else $error("idle with a non-final result pending");

endmodule

FILE: tb/sv/tb_multi_timer_table.sv
module tb_multi_timer_table import mtt_pkg::*; ();

    localparam int NUM_TIMERS = 16;
    localparam int TIME_BITS  = 32;

    // Random part: 335 counted words after the directed opening
    localparam int RANDOM_WORDS = 335;
    // No idling on either side once this few words are left to send
    localparam int QUIET_TAIL   = 60;
    // Sized for the worst tick, with every timer firing
    localparam int DRAIN_CYCLES = 320;

    // Countdown floor -(2^TIME_BITS)
    localparam longint COUNT_FLOOR = -(longint'(1) << TIME_BITS);

    typedef struct {
        logic [REQ_W-1:0]     req_type;
        logic [IN_TIME_W-1:0] interval;
        logic                 repeat_req;
        logic [ID_W-1:0]      timer_id;
        logic [IN_TIME_W-1:0] elapsed;
    } req_word_t;

    logic clk = 1'b0;
    logic rst_n;

    mtt_req_if req_ch ();
    mtt_rsp_if rsp_ch ();

    multi_timer_table #(
        .NUM_TIMERS (NUM_TIMERS),
        .TIME_BITS  (TIME_BITS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Words waiting to be sent, and result words still owed by the block
    req_word_t pending_words[$];
    result_t   expected_results[$];
    req_word_t cur_word;

    // Shadow of the timer table
    logic [ID_W-1:0]      last_id;
    logic                 tmr_live      [NUM_TIMERS];
    logic [ID_W-1:0]      tmr_id        [NUM_TIMERS];
    longint               tmr_count     [NUM_TIMERS];
    logic [TIME_BITS-1:0] tmr_period    [NUM_TIMERS];
    logic                 tmr_periodic  [NUM_TIMERS];
    logic                 tmr_cancelled [NUM_TIMERS];

    int errors;
    int sched_queued;
    int n_sched, n_full, n_cancel, n_tick, n_fired, max_fired, n_checked;
    int req_gap, rsp_stall;
    result_t want;

    function automatic bit in_tail();
        return pending_words.size() < QUIET_TAIL;
    endfunction

    // Append one owed result word
    function automatic void owe_result(input result_t r);
        expected_results = {expected_results, r};
    endfunction

    task automatic queue_word(input logic [REQ_W-1:0] kind, input logic [31:0] ival,
                              input logic rep, input logic [ID_W-1:0] id,
                              input logic [31:0] el);
        req_word_t w;
        w.req_type   = kind;
        w.interval   = ival;
        w.repeat_req = rep;
        w.timer_id   = id;
        w.elapsed    = el;
        pending_words = {pending_words, w};
        if (kind == REQ_SCHED)
            sched_queued++;
    endtask

    // Advance the shadow table by one accepted word and queue what it owes
    task automatic predict_results(input req_word_t w);
        int slot;
        int order[NUM_TIMERS];
        int cnt;
        int v;
        int j;
        int fired;
        logic [ID_W-1:0] nid;
        longint c;
        longint room;
        longint e;
        if (w.req_type == REQ_SCHED)
        begin
            n_sched++;
            nid  = last_id + 1'b1;
            slot = -1;
            // A live slot holding the new id is taken over, else the first free one
            for (int i = 0; i < NUM_TIMERS; i++)
                if (slot < 0 && tmr_live[i] && tmr_id[i] == nid)
                    slot = i;
            for (int i = 0; i < NUM_TIMERS; i++)
                if (slot < 0 && !tmr_live[i])
                    slot = i;
            if (slot < 0)
            begin
                n_full++;
                owe_result('{kind: RK_FULL, id: '0, last: 1'b1});
            end
            else
            begin
                last_id             = nid;
                tmr_live[slot]      = 1'b1;
                tmr_id[slot]        = nid;
                tmr_period[slot]    = w.interval[TIME_BITS-1:0];
                tmr_count[slot]     = longint'(w.interval[TIME_BITS-1:0]);
                tmr_periodic[slot]  = w.repeat_req;
                tmr_cancelled[slot] = 1'b0;
                owe_result('{kind: RK_ASSIGNED, id: nid, last: 1'b1});
            end
        end
        else if (w.req_type == REQ_CANCEL)
        begin
            n_cancel++;
            for (int i = 0; i < NUM_TIMERS; i++)
                if (tmr_live[i] && tmr_id[i] == w.timer_id)
                    tmr_cancelled[i] = 1'b1;
            owe_result('{kind: RK_CANCEL, id: '0, last: 1'b1});
        end
        else if (w.req_type == REQ_TICK)
        begin
            n_tick++;
            fired = 0;
            cnt   = 0;
            e     = longint'(w.elapsed[TIME_BITS-1:0]);
            for (int i = 0; i < NUM_TIMERS; i++)
                if (tmr_live[i])
                begin
                    order[cnt] = i;
                    cnt++;
                end
            // Visit live timers in ascending id order
            for (int i = 1; i < cnt; i++)
            begin
                v = order[i];
                j = i - 1;
                while (j >= 0 && tmr_id[order[j]] > tmr_id[v])
                begin
                    order[j + 1] = order[j];
                    j--;
                end
                order[j + 1] = v;
            end
            for (int i = 0; i < cnt; i++)
            begin
                slot = order[i];
                if (tmr_cancelled[slot])
                begin
                    tmr_live[slot] = 1'b0;
                end
                else
                begin
                    c    = tmr_count[slot];
                    room = c - COUNT_FLOOR;
                    c    = (e > room) ? COUNT_FLOOR : c - e;
                    if (c <= 0)
                    begin
                        fired++;
                        owe_result('{kind: RK_FIRED, id: tmr_id[slot], last: 1'b0});
                        if (tmr_periodic[slot])
                            c = c + longint'(tmr_period[slot]);
                        else
                            tmr_live[slot] = 1'b0;
                    end
                    tmr_count[slot] = c;
                end
            end
            n_fired += fired;
            if (fired > max_fired)
                max_fired = fired;
            owe_result('{kind: RK_TICK_DONE, id: '0, last: 1'b1});
        end
        // Request type 3 is dropped by the block and owes nothing
    endtask

    // Request driver: hold a word until taken, idle in bursts between words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid      <= 1'b0;
            req_ch.req_type   <= REQ_SCHED;
            req_ch.interval   <= '0;
            req_ch.repeat_req <= 1'b0;
            req_ch.timer_id   <= '0;
            req_ch.elapsed    <= '0;
            req_gap = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                predict_results(cur_word);
            if (!req_ch.valid || req_ch.ready)
            begin
                if (req_gap > 0)
                begin
                    req_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (!in_tail() && $urandom_range(0, 7) == 0)
                begin
                    // Start an idle burst
                    req_gap = $urandom_range(0, 18);
                    req_ch.valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    cur_word = pending_words.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.req_type   <= cur_word.req_type;
                    req_ch.interval   <= cur_word.interval;
                    req_ch.repeat_req <= cur_word.repeat_req;
                    req_ch.timer_id   <= cur_word.timer_id;
                    req_ch.elapsed    <= cur_word.elapsed;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each taken word against the oldest expectation,
    // then decide ready for the next cycle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_stall = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                n_checked++;
                if (expected_results.size() == 0)
                begin
                    $error("result word with nothing expected: kind %0d id %0d last %0d",
                           rsp_ch.result_kind, rsp_ch.result_id, rsp_ch.last);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_ch.result_kind !== want.kind)
                    begin
                        $error("result_kind: expected %0d, got %0d", want.kind,
                               rsp_ch.result_kind);
                        errors++;
                    end
                    if (rsp_ch.result_id !== want.id)
                    begin
                        $error("result_id: expected %0d, got %0d", want.id, rsp_ch.result_id);
                        errors++;
                    end
                    if (rsp_ch.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, rsp_ch.last);
                        errors++;
                    end
                end
            end
            if (rsp_stall > 0)
            begin
                rsp_stall--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!in_tail() && $urandom_range(0, 9) == 0)
            begin
                // Start an output stall
                rsp_stall = $urandom_range(0, 18);
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("** multi_timer_table: FAILED **");
        $finish;
    end

    initial
    begin
        int pick;
        int lo;
        int counted;
        logic [31:0] ival;
        logic [31:0] el;
        logic [ID_W-1:0] id;

        // Hold every input at a known value from time zero
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_SCHED;
        req_ch.interval   = '0;
        req_ch.repeat_req = 1'b0;
        req_ch.timer_id   = '0;
        req_ch.elapsed    = '0;
        rsp_ch.ready      = 1'b0;

        errors    = 0;
        last_id   = '0;
        n_sched   = 0;
        n_full    = 0;
        n_cancel  = 0;
        n_tick    = 0;
        n_fired   = 0;
        max_fired = 0;
        n_checked = 0;
        sched_queued = 0;
        for (int i = 0; i < NUM_TIMERS; i++)
            tmr_live[i] = 1'b0;

        // Directed opening
        // tick on an empty table: only the done word
        queue_word(REQ_TICK, 32'h0, 1'b0, '0, 32'h0);
        // fill all sixteen slots with the interval extremes and both timer kinds
        queue_word(REQ_SCHED, 32'hffff_ffff, 1'b0, '0, 32'h0);
        queue_word(REQ_SCHED, 32'h0,         1'b1, '0, 32'h0);
        queue_word(REQ_SCHED, 32'h0,         1'b0, '0, 32'h0);
        queue_word(REQ_SCHED, 32'haaaa_aaaa, 1'b1, '0, 32'h0);
        queue_word(REQ_SCHED, 32'h5555_5555, 1'b0, '0, 32'h0);
        queue_word(REQ_SCHED, 32'hffff_ffff, 1'b1, '0, 32'h0);
        for (int i = 0; i < 10; i++)
            queue_word(REQ_SCHED, 32'd100 * (i + 1), i[0], '0, 32'h0);
        // table is full now
        queue_word(REQ_SCHED, 32'd5, 1'b1, '0, 32'h0);
        // cancel a live timer twice, then an id that was never given out
        queue_word(REQ_CANCEL, 32'h0, 1'b0, 31'd4, 32'h0);
        queue_word(REQ_CANCEL, 32'h0, 1'b0, 31'd4, 32'h0);
        queue_word(REQ_CANCEL, 32'h0, 1'b0, ID_MAX, 32'h0);
        // zero elapsed: zero-interval timers fire, the cancelled one drops
        queue_word(REQ_TICK, 32'h0, 1'b0, '0, 32'h0);
        // two maximal ticks drive the zero-period timer into the floor
        queue_word(REQ_TICK, 32'h0, 1'b0, '0, 32'hffff_ffff);
        queue_word(REQ_TICK, 32'h0, 1'b0, '0, 32'hffff_ffff);
        // unused request type: no result
        queue_word(2'd3, 32'hffff_ffff, 1'b1, ID_MAX, 32'hffff_ffff);

        // Random part: mostly small intervals and elapsed times so timers
        // fire and slots turn over; cancels mostly hit recent ids
        counted = 0;
        while (counted < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            ival = $urandom();
            el   = $urandom();
            id   = ID_W'($urandom());
            if (pick < 4)
            begin
                queue_word(2'd3, ival, 1'($urandom_range(0, 1)), id, el);
            end
            else if (pick < 44)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    ival = $urandom_range(0, 600);
                else if (pick < 85)
                    ival = $urandom_range(0, 20);
                queue_word(REQ_SCHED, ival, 1'($urandom_range(0, 1)), id, el);
                counted++;
            end
            else if (pick < 62)
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    lo = (sched_queued > 24) ? sched_queued - 24 : 1;
                    id = ID_W'($urandom_range(lo, sched_queued));
                end
                queue_word(REQ_CANCEL, ival, 1'($urandom_range(0, 1)), id, el);
                counted++;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    el = $urandom_range(0, 300);
                else if (pick < 90)
                    el = 32'h0;
                queue_word(REQ_TICK, ival, 1'($urandom_range(0, 1)), id, el);
                counted++;
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Let every word go out and every owed result come back
        while (pending_words.size() != 0 || req_ch.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d schedules (%0d refused on a full table), %0d cancels, %0d ticks.",
                 n_sched, n_full, n_cancel, n_tick);
        $display("Saw %0d timer firings, up to %0d in one tick; %0d result words checked.",
                 n_fired, max_fired, n_checked);
        if (errors == 0)
            $display("** multi_timer_table: PASSED **");
        else
            $display("** multi_timer_table: FAILED **");
        $finish;
    end

endmodule
